// ===== rtl/core/md5_stream_hash_defines.svh =====
// Shared assertion macros for the md5 stream hash block.
`ifndef MD5_STREAM_HASH_DEFINES_SVH
`define MD5_STREAM_HASH_DEFINES_SVH

// same-cycle implication
`define MD5SH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("md5sh check failed");

// next-cycle implication
`define MD5SH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("md5sh check failed");

`endif

// ===== rtl/core/md5sh_pkg.sv =====
package md5sh_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS = 6'd56;

    typedef enum logic [1:0] {
        BUF_NOP,
        BUF_ABSORB,
        BUF_PAD,
        BUF_LEN
    } t_buf_op;

    typedef struct packed {
        t_buf_op     op;
        logic [5:0]  pos;
        logic [2:0]  nbytes;
        logic [31:0] data;
        logic [63:0] bits;
    } t_buf_ctl;

    function automatic logic [4:0] rot_amt(input logic [3:0] sel);
        logic [4:0] r;
        case (sel)
            4'd0:  r = 5'd7;
            4'd1:  r = 5'd12;
            4'd2:  r = 5'd17;
            4'd3:  r = 5'd22;
            4'd4:  r = 5'd5;
            4'd5:  r = 5'd9;
            4'd6:  r = 5'd14;
            4'd7:  r = 5'd20;
            4'd8:  r = 5'd4;
            4'd9:  r = 5'd11;
            4'd10: r = 5'd16;
            4'd11: r = 5'd23;
            4'd12: r = 5'd6;
            4'd13: r = 5'd10;
            4'd14: r = 5'd15;
            default: r = 5'd21;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] step_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'hd76aa478;
            6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;
            6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;
            6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;
            6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;
            6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;
            6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;
            6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;
            6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;
            6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;
            6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;
            6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;
            6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;
            6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;
            6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;
            6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;
            6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;
            6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;
            6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;
            6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;
            6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;
            6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;
            6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;
            6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/core/md5sh_step.sv =====
module md5sh_step (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    input  logic [31:0] i_d,
    input  logic [5:0]  i_step,
    input  logic [31:0] i_m,
    output logic [3:0]  o_widx,
    output logic [31:0] o_a,
    output logic [31:0] o_b,
    output logic [31:0] o_c,
    output logic [31:0] o_d
);

    logic [1:0]  w_round;
    logic [31:0] w_f;
    logic [31:0] w_sum;
    logic [4:0]  w_rot;
    logic [63:0] w_dbl;

    assign w_round = i_step[5:4];

    always_comb begin
        case (w_round)
            2'd0: begin
                w_f    = i_d ^ (i_b & (i_c ^ i_d));
                o_widx = i_step[3:0];
            end
            2'd1: begin
                w_f    = i_c ^ (i_d & (i_b ^ i_c));
                o_widx = 4'(i_step[3:0] * 4'd5 + 4'd1);
            end
            2'd2: begin
                w_f    = i_b ^ i_c ^ i_d;
                o_widx = 4'(i_step[3:0] * 4'd3 + 4'd5);
            end
            default: begin
                w_f    = i_c ^ (i_b | ~i_d);
                o_widx = 4'(i_step[3:0] * 4'd7);
            end
        endcase
    end

    assign w_sum = i_a + w_f + md5sh_pkg::step_k(i_step) + i_m;
    assign w_rot = md5sh_pkg::rot_amt({w_round, i_step[1:0]});
    assign w_dbl = {w_sum, w_sum} << w_rot;

    assign o_a = i_d;
    assign o_b = i_b + w_dbl[63:32];
    assign o_c = i_b;
    assign o_d = i_c;

endmodule

// ===== rtl/core/md5sh_buf.sv =====
module md5sh_buf (
    input  logic                 i_clk,
    input  md5sh_pkg::t_buf_ctl  i_ctl,
    input  logic [3:0]           i_rd_idx,
    output logic [31:0]          o_rd_data
);

    logic [15:0][31:0] r_mem;
    logic [15:0][31:0] n_mem;

    always_comb begin
        logic [5:0] p;
        logic [5:0] d6;
        n_mem = r_mem;
        for (int idx = 0; idx < 16; idx++) begin
            for (int lane = 0; lane < 4; lane++) begin
                p  = 6'(idx * 4 + lane);
                d6 = p - i_ctl.pos;
                case (i_ctl.op)
                    md5sh_pkg::BUF_ABSORB: begin
                        if (p >= i_ctl.pos && d6 < {3'd0, i_ctl.nbytes}) begin
                            n_mem[idx][lane*8 +: 8] = i_ctl.data[d6[1:0]*8 +: 8];
                        end
                    end
                    md5sh_pkg::BUF_PAD: begin
                        if (p == i_ctl.pos) begin
                            n_mem[idx][lane*8 +: 8] = md5sh_pkg::PAD_BYTE;
                        end else if (p > i_ctl.pos) begin
                            n_mem[idx][lane*8 +: 8] = 8'd0;
                        end
                    end
                    md5sh_pkg::BUF_LEN: begin
                        n_mem[idx][lane*8 +: 8] = 8'd0;
                    end
                    default: begin
                    end
                endcase
            end
        end
        if ((i_ctl.op == md5sh_pkg::BUF_PAD && i_ctl.pos < md5sh_pkg::LEN_POS)
            || i_ctl.op == md5sh_pkg::BUF_LEN) begin
            n_mem[14] = i_ctl.bits[31:0];
            n_mem[15] = i_ctl.bits[63:32];
        end
    end

    always_ff @(posedge i_clk) begin
        r_mem <= n_mem;
    end

    assign o_rd_data = r_mem[i_rd_idx];

endmodule

// ===== rtl/core/md5_stream_hash.sv =====
// A word that fills no block is absorbed in S_ABSORB, then the block idles or pads; each full
// 64-byte block adds 64 steps on the shared step unit, the chaining add, then the word resumes.
// Last word: one or two padding passes, then S_FIN loads the digest register once the output is free.
// Input: one word at a time; o_in_stall stays high until the block is back in S_IDLE.
// Reset (synchronous, i_rst_n low): idle, no digest pending, initial chaining words, count zero.
`include "md5_stream_hash_defines.svh"

module md5_stream_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_start_of_message,
    input  logic        i_last_of_message,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_digest_first_half,
    output logic [63:0] o_digest_second_half
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ABSORB,
        S_PAD,
        S_LEN,
        S_RUN,
        S_ADD,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        PH_ABSORB,
        PH_PAD,
        PH_LEN
    } t_phase;

    t_state            r_state, n_state;
    t_phase            r_phase, n_phase;
    logic [31:0]       r_word, n_word;
    logic [2:0]        r_cnt, n_cnt;
    logic [2:0]        r_k, n_k;
    logic              r_last, n_last;
    logic [60:0]       r_total, n_total;
    logic [3:0][31:0]  r_chain, n_chain;
    logic [31:0]       r_a, r_b, r_c, r_d, n_a, n_b, n_c, n_d;
    logic [5:0]        r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic [63:0]       r_dig0, r_dig1, n_dig0, n_dig1;

    md5sh_pkg::t_buf_ctl w_ctl;
    logic [3:0]        w_widx;
    logic [31:0]       w_m;
    logic [31:0]       w_sa, w_sb, w_sc, w_sd;
    logic [5:0]        w_pos;
    logic [2:0]        w_rem;
    logic [6:0]        w_space;
    logic [2:0]        w_n;
    logic              w_out_free;

    localparam logic [3:0][31:0] IV = {md5sh_pkg::IV_D, md5sh_pkg::IV_C,
                                       md5sh_pkg::IV_B, md5sh_pkg::IV_A};

    md5sh_step u_step (
        .i_a    (r_a),
        .i_b    (r_b),
        .i_c    (r_c),
        .i_d    (r_d),
        .i_step (r_step),
        .i_m    (w_m),
        .o_widx (w_widx),
        .o_a    (w_sa),
        .o_b    (w_sb),
        .o_c    (w_sc),
        .o_d    (w_sd)
    );

    md5sh_buf u_buf (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_rd_idx  (w_widx),
        .o_rd_data (w_m)
    );

    assign w_pos      = r_total[5:0];
    assign w_rem      = r_cnt - r_k;
    assign w_space    = 7'd64 - {1'b0, w_pos};
    assign w_n        = ({4'd0, w_rem} < w_space) ? w_rem : w_space[2:0];
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_word      = r_word;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_last      = r_last;
        n_total     = r_total;
        n_chain     = r_chain;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_d         = r_d;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_dig0      = r_dig0;
        n_dig1      = r_dig1;
        w_ctl.op     = md5sh_pkg::BUF_NOP;
        w_ctl.pos    = w_pos;
        w_ctl.nbytes = w_n;
        w_ctl.data   = r_word >> {r_k[1:0], 3'b000};
        w_ctl.bits   = {r_total, 3'b000};

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_word = i_data_word;
                    n_cnt  = (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;
                    n_last = i_last_of_message;
                    n_k    = 3'd0;
                    if (i_start_of_message) begin
                        n_chain = IV;
                        n_total = '0;
                    end
                    n_state = S_ABSORB;
                end
            end
            S_ABSORB: begin
                w_ctl.op = md5sh_pkg::BUF_ABSORB;
                n_total  = r_total + 61'(w_n);
                n_k      = r_k + w_n;
                if ({1'b0, w_pos} + {4'd0, w_n} == 7'd64) begin
                    n_state = S_RUN;
                    n_phase = PH_ABSORB;
                    n_step  = '0;
                    {n_d, n_c, n_b, n_a} = r_chain;
                end else begin
                    n_state = r_last ? S_PAD : S_IDLE;
                end
            end
            S_PAD: begin
                w_ctl.op = md5sh_pkg::BUF_PAD;
                n_state  = S_RUN;
                n_phase  = (w_pos >= md5sh_pkg::LEN_POS) ? PH_PAD : PH_LEN;
                n_step   = '0;
                {n_d, n_c, n_b, n_a} = r_chain;
            end
            S_LEN: begin
                w_ctl.op = md5sh_pkg::BUF_LEN;
                n_state  = S_RUN;
                n_phase  = PH_LEN;
                n_step   = '0;
                {n_d, n_c, n_b, n_a} = r_chain;
            end
            S_RUN: begin
                n_a    = w_sa;
                n_b    = w_sb;
                n_c    = w_sc;
                n_d    = w_sd;
                n_step = r_step + 6'd1;
                if (r_step == '1) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_chain[0] = r_chain[0] + r_a;
                n_chain[1] = r_chain[1] + r_b;
                n_chain[2] = r_chain[2] + r_c;
                n_chain[3] = r_chain[3] + r_d;
                case (r_phase)
                    PH_ABSORB: n_state = S_ABSORB;
                    PH_PAD:    n_state = S_LEN;
                    default:   n_state = S_FIN;
                endcase
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_dig0      = {r_chain[1], r_chain[0]};
                    n_dig1      = {r_chain[3], r_chain[2]};
                    n_out_valid = 1'b1;
                    n_chain     = IV;
                    n_total     = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_ABSORB;
            r_k         <= '0;
            r_cnt       <= '0;
            r_last      <= 1'b0;
            r_total     <= '0;
            r_chain     <= IV;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_k         <= n_k;
            r_cnt       <= n_cnt;
            r_last      <= n_last;
            r_total     <= n_total;
            r_chain     <= n_chain;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
        r_word <= n_word;
        r_a    <= n_a;
        r_b    <= n_b;
        r_c    <= n_c;
        r_d    <= n_d;
        r_dig0 <= n_dig0;
        r_dig1 <= n_dig1;
    end

    assign o_in_stall           = (r_state != S_IDLE);
    assign o_out_valid          = r_out_valid;
    assign o_digest_first_half  = r_dig0;
    assign o_digest_second_half = r_dig1;

    `MD5SH_ASSERT_NXT(a_accept_absorbs, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_state == S_ABSORB)
    `MD5SH_ASSERT_IMP(a_run_starts_at_zero, i_clk, i_rst_n, r_state == S_RUN && $past(r_state) != S_RUN, r_step == 6'd0)
    `MD5SH_ASSERT_IMP(a_digest_from_fin, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_FIN)
    `MD5SH_ASSERT_NXT(a_fin_reinit, i_clk, i_rst_n, r_state == S_FIN && w_out_free, r_chain == IV && r_total == 61'd0)

endmodule
